>>> sv/hrsl_pkg.sv
package hrsl_pkg;

   localparam int CNT_W = 13;
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam int IDX_W = 12;
   localparam int PT_W = 32;
   localparam int SRV_W = 8;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_WRAP = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic action;
      logic [IDX_W-1:0] entry_index;
      logic [PT_W-1:0] entry_point;
      logic [SRV_W-1:0] entry_server;
      logic [PT_W-1:0] key_hash;
   } req_type;

   typedef struct packed {
      logic [SRV_W-1:0] server;
      logic [IDX_W-1:0] position;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic more;
      logic rsp_free;
   } sts_type;

endpackage

>>> sv/hrsl_ram.sv
module hrsl_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/hrsl_ctrl.sv
module hrsl_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_action,
   output logic req_ready,
   input  hrsl_pkg::sts_type sts,
   output hrsl_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SEARCH = 3'b010,
      S_RESULT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == hrsl_pkg::ACT_LOOKUP) begin
                  cmd.start = 1'b1;
                  state_in = sts.empty ? S_RESULT : S_SEARCH;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_SEARCH: begin
            cmd.step = 1'b1;
            if (!sts.more) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/hrsl_dpath.sv
module hrsl_dpath #(
   parameter int MAX_POINTS = 4096,
   parameter int SERVER_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  hrsl_pkg::req_type req_data,
   input  logic csr_valid,
   input  logic [hrsl_pkg::CNT_W-1:0] csr_data,
   input  logic rsp_ready,
   output logic rsp_valid,
   output hrsl_pkg::rsp_type rsp_data,
   input  hrsl_pkg::cmd_type cmd,
   output hrsl_pkg::sts_type sts
);

   localparam int CW = hrsl_pkg::CNT_W;
   localparam int IW = hrsl_pkg::IDX_W;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int XW = (AW > CW) ? AW : CW;
   localparam int SW = (SERVER_BITS > hrsl_pkg::SRV_W) ? SERVER_BITS : hrsl_pkg::SRV_W;
   localparam int DW = hrsl_pkg::PT_W + SERVER_BITS;
   localparam logic [CW-1:0] N_CAP =
      (MAX_POINTS < hrsl_pkg::CNT_MAX) ? CW'(MAX_POINTS) : CW'(hrsl_pkg::CNT_MAX);
   localparam bit IDX_ALL = MAX_POINTS >= (1 << IW);
   localparam logic [IW-1:0] IDX_LIM = IDX_ALL ? '1 : IW'(MAX_POINTS);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] sel_ff, sel_in;
   logic [hrsl_pkg::PT_W-1:0] hash_ff;
   hrsl_pkg::status_type status_ff;
   logic rsp_valid_ff;
   hrsl_pkg::rsp_type rsp_data_ff;

   logic [CW-1:0] n_cur;
   logic [CW:0] mid_sum;
   logic go_right;
   logic more;
   logic wrap;
   logic [CW-1:0] rd_idx;
   logic [XW-1:0] rd_ext;
   logic [XW-1:0] wr_ext;
   logic [SW-1:0] srv_in_ext;
   logic [SW-1:0] srv_out_ext;
   logic idx_ok;
   logic [DW-1:0] ram_rd;
   logic [hrsl_pkg::PT_W-1:0] rd_point;

   assign n_cur = (count_ff > N_CAP) ? N_CAP : count_ff;

   assign rd_point = ram_rd[SERVER_BITS +: hrsl_pkg::PT_W];
   assign go_right = rd_point < hash_ff;
   assign lo_in = go_right ? mid_ff + CW'(1) : lo_ff;
   assign hi_in = go_right ? hi_ff : mid_ff;
   assign mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in = mid_sum[CW:1];
   assign more = lo_in < hi_in;
   // lower bound ran off the end: wrap to the first entry
   assign wrap = lo_in >= n_ff;
   assign sel_in = wrap ? '0 : lo_in;

   always_comb begin
      priority if (cmd.start) begin
         rd_idx = n_cur >> 1;
      end else if (more) begin
         rd_idx = mid_in;
      end else begin
         rd_idx = sel_in;
      end
   end

   assign rd_ext = XW'(rd_idx);
   assign wr_ext = XW'(req_data.entry_index);
   assign idx_ok = IDX_ALL || (req_data.entry_index < IDX_LIM);
   assign srv_in_ext = SW'(req_data.entry_server);
   assign srv_out_ext = SW'(ram_rd[SERVER_BITS-1:0]);

   hrsl_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_POINTS)
   ) u_ram (
      .clock(clock),
      .wr_en(cmd.load && idx_ok),
      .wr_addr(wr_ext[AW-1:0]),
      .wr_data({req_data.entry_point, srv_in_ext[SERVER_BITS-1:0]}),
      .rd_en(cmd.start || cmd.step),
      .rd_addr(rd_ext[AW-1:0]),
      .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hash_ff <= req_data.key_hash;
         n_ff <= n_cur;
         lo_ff <= '0;
         hi_ff <= n_cur;
         mid_ff <= n_cur >> 1;
         sel_ff <= '0;
         status_ff <= hrsl_pkg::ST_EMPTY;
      end else if (cmd.step) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         if (more) begin
            mid_ff <= mid_in;
         end else begin
            sel_ff <= sel_in;
            status_ff <= wrap ? hrsl_pkg::ST_WRAP : hrsl_pkg::ST_FOUND;
         end
      end
      if (cmd.finish) begin
         rsp_data_ff.server <= (status_ff == hrsl_pkg::ST_EMPTY) ?
            '0 : srv_out_ext[hrsl_pkg::SRV_W-1:0];
         rsp_data_ff.position <= sel_ff[IW-1:0];
         rsp_data_ff.status <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            count_ff <= csr_data;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.empty = n_cur == '0;
   assign sts.more = more;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> sv/hash_ring_server_lookup.sv
// Consistent-hash ring lookup. Load items write one (point, server) entry into the
// table; software keeps the points ascending and sets the count register (counts
// above MAX_POINTS act as MAX_POINTS) while the block is idle. A lookup does a
// lower-bound binary search with one table RAM read per step, wrapping to entry 0 when
// the hash is above every point; an empty table skips the search before its result is
// registered. A finished result waits in the output register while the next item is
// accepted. The table has no reset: entries in use must be loaded before a lookup
// reaches them.
module hash_ring_server_lookup #(
   parameter int MAX_POINTS = 4096,
   parameter int SERVER_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  hrsl_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output hrsl_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [hrsl_pkg::CNT_W-1:0] csr_data
);

   hrsl_pkg::cmd_type cmd;
   hrsl_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   hrsl_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_action(req_data.action),
      .req_ready(req_ready),
      .sts(sts),
      .cmd(cmd)
   );

   hrsl_dpath #(
      .MAX_POINTS(MAX_POINTS),
      .SERVER_BITS(SERVER_BITS)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .csr_valid(csr_valid && csr_ready),
      .csr_data(csr_data),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .cmd(cmd),
      .sts(sts)
   );

   // an accepted lookup keeps the block busy in the following cycle
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action == hrsl_pkg::ACT_LOOKUP |=> !req_ready)
      else $error("lookup transfer not followed by busy cycle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == hrsl_pkg::ST_EMPTY |->
         rsp_data.server == '0 && rsp_data.position == '0)
      else $error("empty-table result carries nonzero fields");

   a_wrap_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == hrsl_pkg::ST_WRAP |-> rsp_data.position == '0)
      else $error("wrapped result not at entry 0");

endmodule
